[src/tqsa_pkg.sv]
// Package with the types, codes and sizes shared by the superframe assembler.
package tqsa_pkg;

    localparam int unsigned CHANNELS    = 3;
    localparam int unsigned FRAME_WORDS = 64;
    localparam int unsigned QUEUE_DEPTH = 256;
    localparam int unsigned WORD_BITS   = 32;

    localparam int unsigned QA_BITS     = $clog2(QUEUE_DEPTH);
    localparam int unsigned QC_BITS     = QA_BITS + 1;
    localparam int unsigned FI_BITS     = $clog2(FRAME_WORDS);
    localparam int unsigned FF_BITS     = FI_BITS + 1;
    localparam int unsigned CH_BITS     = 2;
    localparam int unsigned FRAME_DEPTH = CHANNELS * FRAME_WORDS;
    localparam int unsigned FA_BITS     = CH_BITS + FI_BITS;

    // Commands.
    localparam logic [1:0] CMD_PUSH_PACKET = 2'd0;
    localparam logic [1:0] CMD_PUSH_STREAM = 2'd1;
    localparam logic [1:0] CMD_TICK        = 2'd2;

    // Frame kinds.
    localparam logic [1:0] KIND_A = 2'd0;
    localparam logic [1:0] KIND_B = 2'd1;
    localparam logic [1:0] KIND_D = 2'd2;
    localparam logic [1:0] KIND_C = 2'd3;

    // Phase codes.
    localparam logic [3:0] PH_A       = 4'd0;
    localparam logic [3:0] PH_B       = 4'd1;
    localparam logic [3:0] PH_D_FIRST = 4'd2;
    localparam logic [3:0] PH_D_LAST  = 4'd9;
    localparam logic [3:0] PH_C       = 4'd10;
    localparam logic [3:0] PH_TOPUP   = 4'd11;

    typedef struct packed {
        logic [1:0]           command;
        logic [1:0]           channel;
        logic [WORD_BITS-1:0] word_in;
    } t_req;

    typedef struct packed {
        logic [1:0]           out_channel;
        logic [1:0]           frame_kind;
        logic [WORD_BITS-1:0] word_out;
        logic                 last_word;
    } t_res;

endpackage

[src/two_queue_superframe_assembler_unit.sv]
// Top level of the two-queue superframe assembler.
//
// A push request is taken and busy stays low. A service tick reads the channel
// state, moves queued words into the channel frame buffer one word per cycle (zero
// padding for a B frame is also written one word per cycle), and, when the frame is
// full, streams it out one word per cycle with o_valid high for each word. A C tick
// may need two drain passes. The last word shows in the same cycle that busy falls.
// The frame memory has a single write port. The receiver cannot stall: every word
// is shown for exactly one cycle and must be taken then.
module two_queue_superframe_assembler_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  tqsa_pkg::t_req  i_req,
    output logic            busy,
    output logic            o_valid,
    output tqsa_pkg::t_res  o_res
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_EVAL  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    // Storage.
    logic [tqsa_pkg::WORD_BITS-1:0] packet_mem [tqsa_pkg::QUEUE_DEPTH];
    logic [tqsa_pkg::WORD_BITS-1:0] stream_mem [tqsa_pkg::QUEUE_DEPTH];
    logic [tqsa_pkg::WORD_BITS-1:0] frame_mem  [tqsa_pkg::FRAME_DEPTH];

    t_state                          r_state;
    logic [tqsa_pkg::QA_BITS-1:0]    r_phead, r_shead;
    logic [tqsa_pkg::QC_BITS-1:0]    r_pcount, r_scount;
    logic [tqsa_pkg::FF_BITS-1:0]    r_fill  [tqsa_pkg::CHANNELS];
    logic [3:0]                      r_phase [tqsa_pkg::CHANNELS];
    logic [tqsa_pkg::CH_BITS-1:0]    r_ch;
    logic [3:0]                      r_ph;
    logic [1:0]                      r_kind;
    logic                            r_src;     // 1 stream, 0 packet
    logic                            r_second;  // C tick: packet pass started
    logic [tqsa_pkg::FF_BITS-1:0]    r_pad;
    logic                            r_pend;
    logic [tqsa_pkg::FA_BITS-1:0]    r_waddr;
    logic [tqsa_pkg::WORD_BITS-1:0]  r_pq, r_sq, r_fq;
    logic [tqsa_pkg::FI_BITS-1:0]    r_idx;
    logic                            r_rd, r_rd_last;
    logic [1:0]                      r_rd_kind;
    logic [tqsa_pkg::CH_BITS-1:0]    r_rd_ch;

    logic                            accept, push_p, push_s, tick_ok;
    logic [tqsa_pkg::FF_BITS-1:0]    cur_fill;
    logic [tqsa_pkg::QC_BITS-1:0]    src_count;
    logic                            can_issue, is_full;
    logic                            fw_en;
    logic [tqsa_pkg::FA_BITS-1:0]    fw_addr;
    logic [tqsa_pkg::WORD_BITS-1:0]  fw_data;
    logic [tqsa_pkg::QC_BITS-1:0]    take;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign push_p   = accept && (i_req.command == tqsa_pkg::CMD_PUSH_PACKET)
                      && (r_pcount < tqsa_pkg::QC_BITS'(tqsa_pkg::QUEUE_DEPTH - 1));
    assign push_s   = accept && (i_req.command == tqsa_pkg::CMD_PUSH_STREAM)
                      && (r_scount < tqsa_pkg::QC_BITS'(tqsa_pkg::QUEUE_DEPTH - 1));
    assign tick_ok  = accept && (i_req.command == tqsa_pkg::CMD_TICK)
                      && (i_req.channel < tqsa_pkg::CH_BITS'(tqsa_pkg::CHANNELS));
    assign cur_fill = r_fill[r_ch];
    assign is_full  = (cur_fill == tqsa_pkg::FF_BITS'(tqsa_pkg::FRAME_WORDS));
    assign src_count = r_src ? r_scount : r_pcount;
    assign can_issue = (src_count != '0) && !is_full;
    assign take = (r_scount < tqsa_pkg::QC_BITS'(tqsa_pkg::FRAME_WORDS))
                  ? r_scount : tqsa_pkg::QC_BITS'(tqsa_pkg::FRAME_WORDS);

    // Frame memory write: zero padding or a word moved from a queue.
    always_comb begin
        fw_en   = 1'b0;
        fw_addr = {r_ch, cur_fill[tqsa_pkg::FI_BITS-1:0]};
        fw_data = '0;
        if (r_state == S_PAD && cur_fill < r_pad) begin
            fw_en = 1'b1;
        end else if (r_state == S_DRAIN && r_pend) begin
            fw_en   = 1'b1;
            fw_addr = r_waddr;
            fw_data = r_src ? r_sq : r_pq;
        end
    end

    // Queue memories: written on a push, read at the head while draining.
    always_ff @(posedge i_clk) begin
        if (push_p) begin
            packet_mem[r_phead + r_pcount[tqsa_pkg::QA_BITS-1:0]] <= i_req.word_in;
        end
        if (push_s) begin
            stream_mem[r_shead + r_scount[tqsa_pkg::QA_BITS-1:0]] <= i_req.word_in;
        end
        r_pq <= packet_mem[r_phead];
        r_sq <= stream_mem[r_shead];
    end

    // Frame memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (fw_en) begin
            frame_mem[fw_addr] <= fw_data;
        end
        r_fq <= frame_mem[{r_ch, r_idx}];
    end

    // Result register.
    always_comb begin
        o_valid           = r_rd;
        o_res.out_channel = r_rd_ch;
        o_res.frame_kind  = r_rd_kind;
        o_res.word_out    = r_fq;
        o_res.last_word   = r_rd_last;
    end

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phead  <= '0;
            r_shead  <= '0;
            r_pcount <= '0;
            r_scount <= '0;
            for (int c = 0; c < tqsa_pkg::CHANNELS; c++) begin
                r_fill[c]  <= '0;
                r_phase[c] <= tqsa_pkg::PH_A;
            end
            r_pend   <= 1'b0;
            r_rd     <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_rd <= 1'b0;
            if (push_p) begin
                r_pcount <= r_pcount + 1'b1;
            end
            if (push_s) begin
                r_scount <= r_scount + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (tick_ok) begin
                        r_ch     <= i_req.channel;
                        r_ph     <= r_phase[i_req.channel];
                        r_second <= 1'b0;
                        r_pend   <= 1'b0;
                        priority if (r_phase[i_req.channel] == tqsa_pkg::PH_B) begin
                            r_fill[i_req.channel] <= '0;
                            r_pad   <= tqsa_pkg::FF_BITS'(tqsa_pkg::FRAME_WORDS)
                                       - take[tqsa_pkg::FF_BITS-1:0];
                            r_src   <= 1'b1;
                            r_state <= S_PAD;
                        end else if (r_phase[i_req.channel] >= tqsa_pkg::PH_D_FIRST
                                     && r_phase[i_req.channel] <= tqsa_pkg::PH_D_LAST) begin
                            r_src <= 1'b1;
                            if (r_scount != '0) begin
                                r_state <= S_DRAIN;
                            end
                        end else if (r_phase[i_req.channel] == tqsa_pkg::PH_C) begin
                            r_src <= 1'b1;
                            if (r_scount != '0 || r_pcount != '0) begin
                                r_state <= S_DRAIN;
                            end
                        end else begin
                            r_src <= 1'b0;
                            if (r_pcount != '0) begin
                                r_state <= S_DRAIN;
                            end
                        end
                    end
                end
                S_PAD: begin
                    if (cur_fill < r_pad) begin
                        r_fill[r_ch] <= cur_fill + 1'b1;
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // Issue one queue read per cycle; its write lands in the next cycle.
                    r_pend <= can_issue;
                    if (can_issue) begin
                        r_waddr      <= {r_ch, cur_fill[tqsa_pkg::FI_BITS-1:0]};
                        r_fill[r_ch] <= cur_fill + 1'b1;
                        if (r_src) begin
                            r_shead  <= r_shead + 1'b1;
                            r_scount <= r_scount - 1'b1;
                        end else begin
                            r_phead  <= r_phead + 1'b1;
                            r_pcount <= r_pcount - 1'b1;
                        end
                    end else if (!r_pend) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_idx   <= '0;
                    r_state <= S_IDLE;
                    priority if (r_ph == tqsa_pkg::PH_B) begin
                        r_phase[r_ch] <= tqsa_pkg::PH_D_FIRST;
                        r_kind        <= tqsa_pkg::KIND_B;
                        r_state       <= S_EMIT;
                    end else if (r_ph >= tqsa_pkg::PH_D_FIRST
                                 && r_ph <= tqsa_pkg::PH_D_LAST) begin
                        if (is_full) begin
                            r_phase[r_ch] <= r_ph + 1'b1;
                            r_kind        <= tqsa_pkg::KIND_D;
                            r_state       <= S_EMIT;
                        end
                    end else if (r_ph == tqsa_pkg::PH_C) begin
                        if (is_full) begin
                            r_phase[r_ch] <= tqsa_pkg::PH_A;
                            r_kind        <= tqsa_pkg::KIND_C;
                            r_state       <= S_EMIT;
                        end else if (r_second) begin
                            r_phase[r_ch] <= tqsa_pkg::PH_TOPUP;
                        end else if (r_pcount != '0) begin
                            r_second <= 1'b1;
                            r_src    <= 1'b0;
                            r_pend   <= 1'b0;
                            r_state  <= S_DRAIN;
                        end
                    end else begin
                        if (is_full) begin
                            r_phase[r_ch] <= (r_ph == tqsa_pkg::PH_TOPUP)
                                             ? tqsa_pkg::PH_A : tqsa_pkg::PH_B;
                            r_kind        <= (r_ph == tqsa_pkg::PH_TOPUP)
                                             ? tqsa_pkg::KIND_C : tqsa_pkg::KIND_A;
                            r_state       <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    // Read one frame word per cycle; it shows on the outputs next cycle.
                    r_rd      <= 1'b1;
                    r_rd_ch   <= r_ch;
                    r_rd_kind <= r_kind;
                    r_rd_last <= (r_idx == tqsa_pkg::FI_BITS'(tqsa_pkg::FRAME_WORDS - 1));
                    r_idx     <= r_idx + 1'b1;
                    if (r_idx == tqsa_pkg::FI_BITS'(tqsa_pkg::FRAME_WORDS - 1)) begin
                        r_fill[r_ch] <= '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
